### hw/rtl/sclf_pkg.sv
// Shared types and codes for the size-class free-list allocator.
// Holds widths, status, opcode and config index codes and the decode result struct; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sclf_pkg;

    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 32;
    localparam int THRESH_W = 17;
    localparam int CLASS_W  = 4;
    localparam int STATUS_W = 3;
    localparam int LOG2_W   = 5;
    // Hard ceiling on the class index carried by the result.
    localparam int MAX_CLASSES = 16;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_REUSED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_POOL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LARGE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREED     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NULL      = 3'd6;

    localparam logic [1:0] CFG_LARGE_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_POOL_BASE       = 2'd1;
    localparam logic [1:0] CFG_POOL_BYTES      = 2'd2;

    // Classification of one request, taken from the request fields and the large-size threshold.
    typedef struct packed {
        logic               is_null;
        logic               is_large;
        logic [CLASS_W-1:0] size_class;
        logic [LOG2_W-1:0]  log2_size;
    } sclf_dec_t;

endpackage
`default_nettype wire

### hw/rtl/sclf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module sclf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### hw/rtl/sclf_decode.sv
// Request classifier: null free, large size, class index and rounded log2 size.
// Depends on sclf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sclf_decode #(
    parameter int NUM_CLASSES = 16
) (
    input  wire logic                           opcode,
    input  wire logic [sclf_pkg::SIZE_W-1:0]    req_size,
    input  wire logic [sclf_pkg::ADDR_W-1:0]    block_address,
    input  wire logic [sclf_pkg::THRESH_W-1:0]  large_threshold,
    output sclf_pkg::sclf_dec_t                 dec
);
    import sclf_pkg::*;

    localparam int EFF_CLASSES = (NUM_CLASSES < MAX_CLASSES) ? NUM_CLASSES : MAX_CLASSES;

    logic [SIZE_W-1:0]   size_eff;
    logic [THRESH_W-1:0] size_m1;
    logic [LOG2_W-1:0]   bit_len;
    logic [LOG2_W-1:0]   cls_wide;
    logic                over;

    always_comb
    begin
        size_eff = (req_size == '0) ? SIZE_W'(1) : req_size;
        over     = size_eff > {{(SIZE_W-THRESH_W){1'b0}}, large_threshold};
        // Ceiling log2 is the bit length of size minus one; valid when not over.
        size_m1  = size_eff[THRESH_W-1:0] - THRESH_W'(1);
        bit_len  = '0;
        for (int i = 0; i < THRESH_W; i++)
        begin
            if (size_m1[i])
            begin
                bit_len = LOG2_W'(i + 1);
            end
        end
        cls_wide = (bit_len == '0) ? '0 : bit_len - LOG2_W'(1);

        dec.is_null    = (opcode == OP_FREE) && (block_address == '0);
        dec.is_large   = over || (cls_wide >= LOG2_W'(EFF_CLASSES));
        dec.size_class = cls_wide[CLASS_W-1:0];
        dec.log2_size  = bit_len;
    end

endmodule
`default_nettype wire

### hw/rtl/size_class_free_list_allocator_unit.sv
// A result is registered by the execute step after its request is accepted; a reuse (pop)
// adds a read step, because the free-stack entry RAM has a registered read. Requests are taken
// one at a time (s_tready only while idle); the execute step is one read-modify-write of a
// class count and entry. A finished result waits in the output register while the next request
// is accepted. Reset (rst_n, async, low): counts and pool offset clear, registers take their
// defaults; stack entries stay undefined until written. Uses sclf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module size_class_free_list_allocator_unit #(
    parameter int NUM_CLASSES = 16,
    parameter int LIST_DEPTH  = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // req_size[31:0], block_address[63:32]
    input  wire logic [0:0]  s_tuser,   // opcode[0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // address[31:0], size_class[35:32], zero pad[39:36]
    output logic [2:0]       m_tuser    // status[2:0]
);
    import sclf_pkg::*;

    localparam int EFF_CLASSES = (NUM_CLASSES < MAX_CLASSES) ? NUM_CLASSES : MAX_CLASSES;
    localparam int CLS_W       = $clog2(EFF_CLASSES);
    localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
    localparam int ENT_DEPTH   = EFF_CLASSES * LIST_DEPTH;
    localparam int ENT_AW      = $clog2(ENT_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    // Configuration registers.
    logic [THRESH_W-1:0] thresh_reg;
    logic [ADDR_W-1:0]   pool_base_reg;
    logic [ADDR_W-1:0]   pool_bytes_reg;

    // Control state.
    logic [1:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   offset_reg, offset_next;
    logic [CNT_W-1:0]    cnt_reg [EFF_CLASSES];
    logic [CNT_W-1:0]    cnt_next;
    logic                cnt_we;
    logic                out_valid_reg, out_valid_next;

    // Request and result payload.
    sclf_dec_t           dec_now;
    sclf_dec_t           dec_reg;
    logic                op_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [CLASS_W-1:0]  out_cls_reg, out_cls_next;
    logic [STATUS_W-1:0] out_st_reg, out_st_next;
    logic                out_load;

    // Execute-step signals.
    logic                accept;
    logic                out_free;
    logic [CLS_W-1:0]    cls_idx;
    logic [CNT_W-1:0]    cnt_cur;
    logic [ENT_AW-1:0]   ent_base;
    logic [ADDR_W:0]     pool_end;
    logic                ram_we;
    logic                ram_re;
    logic [ENT_AW-1:0]   ram_waddr;
    logic [ENT_AW-1:0]   ram_raddr;
    logic [ADDR_W-1:0]   ram_rdata;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Classify straight from the request bus and hold the outcome for execute.
    sclf_decode #(
        .NUM_CLASSES(NUM_CLASSES)
    ) u_decode (
        .opcode          (s_tuser[0]),
        .req_size        (s_tdata[31:0]),
        .block_address   (s_tdata[63:32]),
        .large_threshold (thresh_reg),
        .dec             (dec_now)
    );

    // Free-stack entries, one row of LIST_DEPTH per class. Push and pop belong to different
    // requests with an idle state between their execute steps, so a read never races a write.
    sclf_ram #(
        .WIDTH(ADDR_W),
        .DEPTH(ENT_DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (addr_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cls_idx   = dec_reg.size_class[CLS_W-1:0];
    assign cnt_cur   = cnt_reg[cls_idx];
    assign ent_base  = ENT_AW'(cls_idx) * ENT_AW'(LIST_DEPTH);
    assign ram_waddr = ent_base + ENT_AW'(cnt_cur);
    assign ram_raddr = ent_base + ENT_AW'(cnt_cur - CNT_W'(1));
    // Pool check: offset plus rounded size, kept one bit wider so it cannot wrap.
    assign pool_end  = {1'b0, offset_reg} + ((ADDR_W+1)'(1) << dec_reg.log2_size);

    always_comb
    begin
        state_next     = state_reg;
        offset_next    = offset_reg;
        cnt_next       = cnt_cur;
        cnt_we         = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        out_load       = 1'b0;
        out_addr_next  = '0;
        out_cls_next   = dec_reg.size_class;
        out_st_next    = ST_NULL;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                priority if (dec_reg.is_null)
                begin
                    out_cls_next = '0;
                    out_st_next  = ST_NULL;
                    out_load     = out_free;
                end
                else if (dec_reg.is_large)
                begin
                    out_cls_next = '0;
                    out_st_next  = ST_LARGE;
                    out_load     = out_free;
                end
                else if (op_reg == OP_FREE)
                begin
                    out_load = out_free;
                    if (cnt_cur == CNT_W'(LIST_DEPTH))
                    begin
                        out_st_next = ST_FULL;
                    end
                    else
                    begin
                        out_st_next = ST_FREED;
                        // push: write the entry and bump the count on the same edge
                        ram_we      = out_free;
                        cnt_we      = out_free;
                        cnt_next    = cnt_cur + CNT_W'(1);
                    end
                end
                else if (cnt_cur != '0)
                begin
                    // pop: drop the count now, take the entry from the RAM next cycle
                    ram_re     = 1'b1;
                    cnt_we     = 1'b1;
                    cnt_next   = cnt_cur - CNT_W'(1);
                    state_next = S_READ;
                end
                else if (pool_end > {1'b0, pool_bytes_reg})
                begin
                    out_st_next = ST_EXHAUSTED;
                    out_load    = out_free;
                end
                else
                begin
                    out_addr_next = pool_base_reg + offset_reg;
                    out_st_next   = ST_POOL;
                    out_load      = out_free;
                    if (out_free)
                    begin
                        offset_next = pool_end[ADDR_W-1:0];
                    end
                end
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                out_addr_next = ram_rdata;
                out_st_next   = ST_REUSED;
                out_load      = out_free;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Hold a result until taken; a fresh load replaces one leaving this cycle.
        out_valid_next = out_load || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            offset_reg     <= '0;
            out_valid_reg  <= 1'b0;
            thresh_reg     <= THRESH_W'(17'd65535);
            pool_base_reg  <= 32'd4096;
            pool_bytes_reg <= 32'd1048576;
            for (int i = 0; i < EFF_CLASSES; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            offset_reg    <= offset_next;
            out_valid_reg <= out_valid_next;
            if (cnt_we)
            begin
                cnt_reg[cls_idx] <= cnt_next;
            end
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_LARGE_THRESHOLD: thresh_reg     <= cfg_wdata[THRESH_W-1:0];
                    CFG_POOL_BASE:       pool_base_reg  <= cfg_wdata;
                    CFG_POOL_BYTES:      pool_bytes_reg <= cfg_wdata;
                    default:             ; // unmapped index, drop the write
                endcase
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dec_reg  <= dec_now;
            op_reg   <= s_tuser[0];
            addr_reg <= s_tdata[63:32];
        end
        if (out_load)
        begin
            out_addr_reg <= out_addr_next;
            out_cls_reg  <= out_cls_next;
            out_st_reg   <= out_st_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_cls_reg, out_addr_reg};
    assign m_tuser  = out_st_reg;

endmodule
`default_nettype wire
